[rtl/core/iac_pkg.sv]
package iac_pkg;

	typedef enum logic [2:0] {
		OP_GET  = 3'd0,
		OP_SET  = 3'd1,
		OP_INS  = 3'd2,
		OP_DEL  = 3'd3,
		OP_SRCH = 3'd4
	} iac_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} iac_status_t;

	localparam int WORD_W = 32;
	localparam int POS_W  = 8;
	localparam int CNT_W  = 8;

	typedef struct packed {
		logic set_en;
		logic ins_en;
		logic del_en;
		logic get_en;
		logic srch_en;
	} iac_cmd_t;

endpackage

[rtl/core/iac_cell.sv]
module iac_cell #(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iac_pkg::iac_cmd_t                 upd,
	input  logic [CW-1:0]                     upd_pos,
	input  logic signed [iac_pkg::WORD_W-1:0] value,
	input  logic signed [iac_pkg::WORD_W-1:0] left_data,
	input  logic signed [iac_pkg::WORD_W-1:0] right_data,
	output logic signed [iac_pkg::WORD_W-1:0] data,
	input  iac_pkg::iac_cmd_t                 req,
	input  logic [CW-1:0]                     req_pos,
	input  logic signed [iac_pkg::WORD_W-1:0] req_val,
	input  logic [CW-1:0]                     cnt,
	input  logic                              tok_in,
	input  logic signed [iac_pkg::WORD_W-1:0] acc_word_in,
	input  logic                              acc_hit_in,
	output logic                              tok,
	output logic signed [iac_pkg::WORD_W-1:0] acc_word,
	output logic                              acc_hit
);
	import iac_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic signed [WORD_W-1:0] data_q;
	logic signed [WORD_W-1:0] acc_word_q;
	logic                     acc_hit_q;
	logic                     tok_q;
	logic signed [WORD_W-1:0] loc_word;
	logic                     loc_hit;

	// The entry takes a new value on a write at its index, or from a neighbor on a shift.
	always_ff @(posedge clk) begin
		if (upd.set_en && upd_pos == IDX_C) begin
			data_q <= value;
		end else if (upd.ins_en && upd_pos == IDX_C) begin
			data_q <= value;
		end else if (upd.ins_en && IDX_C > upd_pos) begin
			data_q <= left_data;
		end else if (upd.del_en && IDX_C >= upd_pos) begin
			data_q <= right_data;
		end
	end

	always_comb begin
		loc_word = (req.get_en && req_pos == IDX_C) ? data_q : '0;
		loc_hit  = req.srch_en && (IDX_C < cnt) && (data_q == req_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in) begin
			acc_word_q <= acc_word_in | loc_word;
			acc_hit_q  <= acc_hit_in | loc_hit;
		end
	end

	assign data     = data_q;
	assign tok      = tok_q;
	assign acc_word = acc_word_q;
	assign acc_hit  = acc_hit_q;

endmodule

[rtl/core/iac_ctrl.sv]
module iac_ctrl #(
	parameter int CAPACITY = 128,
	parameter int CW       = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        op,
	input  logic [iac_pkg::POS_W-1:0]         position,
	input  logic signed [iac_pkg::WORD_W-1:0] value,
	output iac_pkg::iac_cmd_t                 upd,
	output logic [CW-1:0]                     upd_pos,
	output iac_pkg::iac_cmd_t                 req,
	output logic [CW-1:0]                     req_pos,
	output logic signed [iac_pkg::WORD_W-1:0] req_val,
	output logic [CW-1:0]                     cnt,
	output logic                              launch,
	input  logic                              tok_last,
	input  logic signed [iac_pkg::WORD_W-1:0] acc_word_last,
	input  logic                              acc_hit_last,
	output logic                              done,
	output logic signed [iac_pkg::WORD_W-1:0] read_word,
	output logic                              found,
	output logic [iac_pkg::CNT_W-1:0]         count,
	output logic [1:0]                        status
);
	import iac_pkg::*;

	localparam int MW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic              busy_q;
	logic              launch_q;
	logic              done_q;
	logic [CW-1:0]     count_q;
	iac_cmd_t          req_q;
	logic [CW-1:0]     req_pos_q;
	logic signed [WORD_W-1:0] req_val_q;
	logic signed [WORD_W-1:0] read_word_q;
	logic              found_q;
	logic [CNT_W-1:0]  count_out_q;
	iac_status_t       status_q;

	logic              acc;
	logic              sweep;
	logic [MW-1:0]     pos_e;
	logic [MW-1:0]     cnt_e;
	logic [MW-1:0]     nxt_e;
	logic              lt;
	logic              eq;
	logic              full;
	logic [CW-1:0]     nxt_cnt;
	iac_status_t       imm_st;
	iac_cmd_t          upd_c;
	iac_cmd_t          req_c;

	assign acc   = start && !busy_q;
	assign pos_e = MW'(position);
	assign cnt_e = MW'(count_q);
	assign nxt_e = MW'(nxt_cnt);
	assign lt    = pos_e < cnt_e;
	assign eq    = pos_e == cnt_e;
	assign full  = count_q == CAP_C;

	always_comb begin
		upd_c   = '0;
		req_c   = '0;
		nxt_cnt = count_q;
		imm_st  = ST_OK;
		sweep   = 1'b0;
		if (acc) begin
			unique case (op)
				OP_GET: begin
					if (lt) begin
						req_c.get_en = 1'b1;
						sweep        = 1'b1;
					end else begin
						imm_st = ST_RANGE;
					end
				end
				OP_SET: begin
					if (lt) begin
						upd_c.set_en = 1'b1;
					end else if (eq && !full) begin
						upd_c.set_en = 1'b1;
						nxt_cnt      = count_q + CW'(1);
					end else if (eq) begin
						imm_st = ST_FULL;
					end else begin
						imm_st = ST_RANGE;
					end
				end
				OP_INS: begin
					if (!lt && !eq) begin
						imm_st = ST_RANGE;
					end else if (full) begin
						imm_st = ST_FULL;
					end else begin
						upd_c.ins_en = 1'b1;
						nxt_cnt      = count_q + CW'(1);
					end
				end
				OP_DEL: begin
					if (lt) begin
						upd_c.del_en = 1'b1;
						nxt_cnt      = count_q - CW'(1);
					end else begin
						imm_st = ST_RANGE;
					end
				end
				OP_SRCH: begin
					req_c.srch_en = 1'b1;
					sweep         = 1'b1;
				end
				default: begin
					imm_st = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			count_q  <= nxt_cnt;
			launch_q <= acc && sweep;
			done_q   <= (acc && !sweep) || tok_last;
			if (acc && sweep) begin
				busy_q <= 1'b1;
			end else if (tok_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q     <= req_c;
			req_pos_q <= CW'(position);
			req_val_q <= value;
		end
		if (acc && !sweep) begin
			read_word_q <= '0;
			found_q     <= 1'b0;
			status_q    <= imm_st;
			count_out_q <= nxt_e[CNT_W-1:0];
		end else if (tok_last) begin
			read_word_q <= acc_word_last;
			found_q     <= acc_hit_last;
			status_q    <= ST_OK;
			count_out_q <= cnt_e[CNT_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign upd       = upd_c;
	assign upd_pos   = CW'(position);
	assign req       = req_q;
	assign req_pos   = req_pos_q;
	assign req_val   = req_val_q;
	assign cnt       = count_q;
	assign launch    = launch_q;
	assign done      = done_q;
	assign read_word = read_word_q;
	assign found     = found_q;
	assign count     = count_out_q;
	assign status    = status_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && busy_q))
		else $error("result strobe while a scan is still running");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last |-> busy_q)
		else $error("scan token left the chain outside a scan");

	a_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == OP_INS && full && (lt || eq)
		|=> done_q && status_q == ST_FULL && $stable(count_q))
		else $error("insert into a full list was not refused");

	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> launch_q)
		else $error("scan started without a token launch");

endmodule

[rtl/core/indexed_array_list.sv]
// Ordered list of up to CAPACITY signed 32-bit words held in a chain of cells, one word per
// cell. Set, insert, delete and any refused request finish in one pass: every cell takes its
// new word from the request or from a neighbor at the accepting edge, and the result strobe
// done rises in the next cycle, so such items may be started back to back. Get and search
// send a token down the cell chain, one cell per cycle, gathering the read word or the hit
// flag; busy stays high until the token leaves the last cell, and no new start is taken
// before then, with done rising at the same edge at which busy falls. Each result is shown
// for one cycle only and must be taken then, since the block cannot be stalled.
module indexed_array_list #(
	parameter int CAPACITY = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        op,
	input  logic [iac_pkg::POS_W-1:0]         position,
	input  logic signed [iac_pkg::WORD_W-1:0] value,
	output logic                              done,
	output logic signed [iac_pkg::WORD_W-1:0] read_word,
	output logic                              found,
	output logic [iac_pkg::CNT_W-1:0]         count,
	output logic [1:0]                        status
);
	import iac_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	iac_cmd_t                 upd;
	iac_cmd_t                 req;
	logic [CW-1:0]            upd_pos;
	logic [CW-1:0]            req_pos;
	logic signed [WORD_W-1:0] req_val;
	logic [CW-1:0]            cnt;
	logic                     launch;

	logic signed [WORD_W-1:0] data_w     [CAPACITY];
	logic signed [WORD_W-1:0] acc_word_w [CAPACITY];
	logic                     acc_hit_w  [CAPACITY];
	logic                     tok_w      [CAPACITY];

	iac_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.position      (position),
		.value         (value),
		.upd           (upd),
		.upd_pos       (upd_pos),
		.req           (req),
		.req_pos       (req_pos),
		.req_val       (req_val),
		.cnt           (cnt),
		.launch        (launch),
		.tok_last      (tok_w[CAPACITY-1]),
		.acc_word_last (acc_word_w[CAPACITY-1]),
		.acc_hit_last  (acc_hit_w[CAPACITY-1]),
		.done          (done),
		.read_word     (read_word),
		.found         (found),
		.count         (count),
		.status        (status)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_d;
		logic signed [WORD_W-1:0] right_d;
		logic signed [WORD_W-1:0] acc_w_in;
		logic                     acc_h_in;
		logic                     tok_in;

		if (i == 0) begin : g_first
			assign left_d   = value;
			assign acc_w_in = '0;
			assign acc_h_in = 1'b0;
			assign tok_in   = launch;
		end else begin : g_mid
			assign left_d   = data_w[i-1];
			assign acc_w_in = acc_word_w[i-1];
			assign acc_h_in = acc_hit_w[i-1];
			assign tok_in   = tok_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = data_w[i];
		end else begin : g_inner
			assign right_d = data_w[i+1];
		end

		iac_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.upd         (upd),
			.upd_pos     (upd_pos),
			.value       (value),
			.left_data   (left_d),
			.right_data  (right_d),
			.data        (data_w[i]),
			.req         (req),
			.req_pos     (req_pos),
			.req_val     (req_val),
			.cnt         (cnt),
			.tok_in      (tok_in),
			.acc_word_in (acc_w_in),
			.acc_hit_in  (acc_h_in),
			.tok         (tok_w[i]),
			.acc_word    (acc_word_w[i]),
			.acc_hit     (acc_hit_w[i])
		);
	end

endmodule
